// ----- hdl/mmsb_pkg.sv -----
// Shared types, constants and the scale/offset derivation for the module blit.
package mmsb_pkg;

   localparam int MAX_SCALE  = 8;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 12;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_BITMAP_WIDTH  = 3'd0,
      CSR_BITMAP_HEIGHT = 3'd1,
      CSR_ROW_STRIDE    = 3'd2,
      CSR_TOP_ROW       = 3'd3,
      CSR_REQ_SCALE     = 3'd4,
      CSR_MODULE_COUNT  = 3'd5
   } csr_index_type;

   typedef struct packed {
      logic [10:0] width;
      logic [11:0] height;
      logic [8:0]  stride;
      logic [11:0] top;
      logic [3:0]  req_scale;
      logic [7:0]  mod_count;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      width:     11'd384,
      height:    12'd1024,
      stride:    9'd48,
      top:       12'd0,
      req_scale: 4'd4,
      mod_count: 8'd29
   };

   typedef struct packed {
      logic [3:0]         scale;
      logic signed [11:0] left_offset;
      logic [10:0]        side;
   } geo_type;

   typedef struct packed {
      logic [7:0] col;
      logic [7:0] row;
   } mod_item_type;

   typedef struct packed {
      logic [19:0] byte_index;
      logic [2:0]  bit_number;
      logic [10:0] side;
      logic        last;
   } rsp_word_type;

   // The cap of width / module_count is found by comparing module_count * k
   // against the width for every candidate scale k.
   function automatic geo_type derive_geo(input cfg_type cfg);
      geo_type            geo;
      logic [3:0]         req_capped;
      logic [3:0]         cap;
      logic [3:0]         scale;
      logic [10:0]        prod;
      logic [10:0]        side;
      logic signed [12:0] diff;
      logic signed [12:0] diff_adj;
      cap = 4'd1;
      req_capped = (cfg.req_scale > 4'(MAX_SCALE)) ? 4'(MAX_SCALE) : cfg.req_scale;
      for (int k = 2; k <= MAX_SCALE; k++) begin
         prod = 11'({3'd0, cfg.mod_count} * 11'(k));
         if (prod <= cfg.width) begin
            cap = 4'(k);
         end
      end
      if (cfg.mod_count == 8'd0) begin
         scale = 4'd0;
      end else begin
         scale = (req_capped < cap) ? req_capped : cap;
      end
      side = 11'({3'd0, cfg.mod_count} * {7'd0, scale});
      diff = $signed({2'd0, cfg.width}) - $signed({2'd0, side});
      diff_adj = diff + $signed({12'd0, diff[12]});
      geo.scale = scale;
      geo.side = side;
      if (cfg.mod_count == 8'd0) begin
         geo.left_offset = 12'sd0;
      end else begin
         geo.left_offset = diff_adj[12:1];
      end
      return geo;
   endfunction

endpackage

// ----- hdl/module_matrix_scaled_blit.sv -----
// Scaled module blit top level: a dark module gives one clear word per visible pixel.
// Throughput: one clear word per cycle while the response queue is not full; a module has
// scale squared visible pixels at most (sixteen at scale four), walked by the pixel walker.
// Light or out-of-matrix modules are dropped in the front end and never reach the back end.
// Reset clears all queues and stages and loads the register defaults; no clearing pass.
module module_matrix_scaled_blit
   import mmsb_pkg::*;
#(
   parameter int QUEUE_DEPTH = 4,
   parameter int RSP_DEPTH = 4
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_write_enable,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data,
   input  logic                  req_push,
   output logic                  req_full,
   input  logic [7:0]            req_module_col,
   input  logic [7:0]            req_module_row,
   input  logic                  req_dark,
   output logic                  rsp_empty,
   input  logic                  rsp_pop,
   output logic [19:0]           rsp_byte_index,
   output logic [2:0]            rsp_bit_number,
   output logic [10:0]           rsp_side_pixels,
   output logic                  rsp_last
);

   cfg_type      cfg_ff;
   cfg_type      cfg_in;
   geo_type      geo;
   logic         q_wr;
   logic         q_full;
   logic         q_rd;
   logic         q_empty;
   mod_item_type q_wdata;
   mod_item_type q_rdata;
   logic         out_wr;
   logic         out_full;
   rsp_word_type out_wdata;
   rsp_word_type out_rdata;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         unique case (csr_index_type'(csr_index))
            CSR_BITMAP_WIDTH:  cfg_in.width = csr_data[10:0];
            CSR_BITMAP_HEIGHT: cfg_in.height = csr_data[11:0];
            CSR_ROW_STRIDE:    cfg_in.stride = csr_data[8:0];
            CSR_TOP_ROW:       cfg_in.top = csr_data[11:0];
            CSR_REQ_SCALE:     cfg_in.req_scale = csr_data[3:0];
            CSR_MODULE_COUNT:  cfg_in.mod_count = csr_data[7:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   mmsb_front u_front (
      .clock          (clock),
      .reset          (reset),
      .cfg            (cfg_ff),
      .req_push       (req_push),
      .req_full       (req_full),
      .req_module_col (req_module_col),
      .req_module_row (req_module_row),
      .req_dark       (req_dark),
      .geo            (geo),
      .q_wr           (q_wr),
      .q_wdata        (q_wdata),
      .q_full         (q_full)
   );

   mmsb_fifo #(
      .WIDTH ($bits(mod_item_type)),
      .DEPTH (QUEUE_DEPTH)
   ) u_mod_queue (
      .clock (clock),
      .reset (reset),
      .wr    (q_wr),
      .wdata (q_wdata),
      .full  (q_full),
      .rd    (q_rd),
      .rdata (q_rdata),
      .empty (q_empty)
   );

   mmsb_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .geo       (geo),
      .q_empty   (q_empty),
      .q_rdata   (q_rdata),
      .q_rd      (q_rd),
      .out_wr    (out_wr),
      .out_wdata (out_wdata),
      .out_full  (out_full)
   );

   mmsb_fifo #(
      .WIDTH ($bits(rsp_word_type)),
      .DEPTH (RSP_DEPTH)
   ) u_rsp_queue (
      .clock (clock),
      .reset (reset),
      .wr    (out_wr),
      .wdata (out_wdata),
      .full  (out_full),
      .rd    (rsp_pop),
      .rdata (out_rdata),
      .empty (rsp_empty)
   );

   assign rsp_byte_index = out_rdata.byte_index;
   assign rsp_bit_number = out_rdata.bit_number;
   assign rsp_side_pixels = out_rdata.side;
   assign rsp_last = out_rdata.last;

`ifndef SYNTHESIS
   assert property (@(posedge clock) disable iff (reset) geo.scale <= 4'(MAX_SCALE))
      else $error("Effective scale exceeds the maximum scale.");

   assert property (@(posedge clock) disable iff (reset)
      (geo.scale > 4'd1) && $stable(cfg_ff.width) && $stable(cfg_ff.mod_count)
      |-> geo.side <= cfg_ff.width)
      else $error("Scaled symbol is wider than the bitmap.");

   assert property (@(posedge clock) disable iff (reset) !rsp_empty |-> rsp_side_pixels != 11'd0)
      else $error("Clear word reports a zero side length.");
`endif

endmodule

// ----- hdl/mmsb_fifo.sv -----
// Small first-in first-out queue built from a register array.
module mmsb_fifo
   import mmsb_pkg::*;
#(
   parameter int WIDTH = 16,
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             wr,
   input  logic [WIDTH-1:0] wdata,
   output logic             full,
   input  logic             rd,
   output logic [WIDTH-1:0] rdata,
   output logic             empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff;
   logic [PTR_W-1:0] wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff;
   logic [PTR_W-1:0] rd_ptr_in;
   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;
   logic             do_wr;
   logic             do_rd;

   assign full  = (count_ff == CNT_W'(DEPTH));
   assign empty = (count_ff == '0);
   assign do_wr = wr && !full;
   assign do_rd = rd && !empty;
   assign rdata = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in = count_ff;
      if (do_wr) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_rd) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_wr && !do_rd) begin
         count_in = count_ff + 1'b1;
      end else if (do_rd && !do_wr) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_wr) begin
         mem_ff[wr_ptr_ff] <= wdata;
      end
   end

endmodule

// ----- hdl/mmsb_front.sv -----
// Front end: takes module words, drops light or off-matrix ones, keeps derived geometry.
module mmsb_front
   import mmsb_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  cfg_type      cfg,
   input  logic         req_push,
   output logic         req_full,
   input  logic [7:0]   req_module_col,
   input  logic [7:0]   req_module_row,
   input  logic         req_dark,
   output geo_type      geo,
   output logic         q_wr,
   output mod_item_type q_wdata,
   input  logic         q_full
);

   geo_type geo_ff;
   geo_type geo_in;
   logic    accept;
   logic    keep;

   assign req_full = q_full;
   assign accept = req_push && !q_full;
   assign keep = req_dark && (req_module_col < cfg.mod_count) &&
                 (req_module_row < cfg.mod_count) && (cfg.req_scale != 4'd0);
   assign q_wr = accept && keep;
   assign q_wdata = '{col: req_module_col, row: req_module_row};
   assign geo = geo_ff;

   always_comb begin
      geo_in = derive_geo(cfg);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         geo_ff <= derive_geo(CFG_RESET);
      end else begin
         geo_ff <= geo_in;
      end
   end

endmodule

// ----- hdl/mmsb_back.sv -----
// Back end: places each module, clips its block to the bitmap and walks its pixels.
module mmsb_back
   import mmsb_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  cfg_type      cfg,
   input  geo_type      geo,
   input  logic         q_empty,
   input  mod_item_type q_rdata,
   output logic         q_rd,
   output logic         out_wr,
   output rsp_word_type out_wdata,
   input  logic         out_full
);

   logic               a_valid_ff;
   logic               a_valid_in;
   logic signed [12:0] a_x0_ff;
   logic signed [12:0] a_x0_in;
   logic [12:0]        a_y0_ff;
   logic [12:0]        a_y0_in;

   logic               b_valid_ff;
   logic               b_valid_in;
   logic               b_empty_ff;
   logic               b_empty_in;
   logic [10:0]        b_xlo_ff;
   logic [10:0]        b_xlo_in;
   logic [10:0]        b_xhi_ff;
   logic [10:0]        b_xhi_in;
   logic [11:0]        b_ylo_ff;
   logic [11:0]        b_ylo_in;
   logic [11:0]        b_yhi_ff;
   logic [11:0]        b_yhi_in;

   logic               it_active_ff;
   logic               it_active_in;
   logic [10:0]        it_x_ff;
   logic [10:0]        it_x_in;
   logic [10:0]        it_xlo_ff;
   logic [10:0]        it_xlo_in;
   logic [10:0]        it_xhi_ff;
   logic [10:0]        it_xhi_in;
   logic [11:0]        it_y_ff;
   logic [11:0]        it_y_in;
   logic [11:0]        it_yhi_ff;
   logic [11:0]        it_yhi_in;

   logic               p_valid_ff;
   logic               p_valid_in;
   logic [10:0]        p_x_ff;
   logic [10:0]        p_x_in;
   logic [11:0]        p_y_ff;
   logic [11:0]        p_y_in;
   logic               p_last_ff;
   logic               p_last_in;

   logic               p_ready;
   logic               it_step;
   logic               it_last;
   logic               it_free;
   logic               it_load;
   logic               b_take;
   logic               b_ready;
   logic               a_move;

   logic [11:0]        prod_x;
   logic [11:0]        prod_y;
   logic signed [13:0] xs;
   logic signed [13:0] ys;
   logic signed [13:0] sc;
   logic signed [13:0] xend;
   logic signed [13:0] yend;
   logic signed [13:0] wm1;
   logic signed [13:0] hm1;
   logic signed [13:0] xlo;
   logic signed [13:0] xhi;
   logic signed [13:0] yhi;
   logic [20:0]        byte_full;

   assign p_ready = !p_valid_ff || !out_full;
   assign it_step = it_active_ff && p_ready;
   assign it_last = (it_x_ff == it_xhi_ff) && (it_y_ff == it_yhi_ff);
   assign it_free = !it_active_ff || (it_step && it_last);
   assign b_take  = b_valid_ff && (b_empty_ff || it_free);
   assign it_load = b_valid_ff && !b_empty_ff && it_free;
   assign b_ready = !b_valid_ff || b_take;
   assign a_move  = a_valid_ff && b_ready;
   assign q_rd    = !q_empty && (!a_valid_ff || b_ready);

   always_comb begin
      prod_x = 12'({4'd0, q_rdata.col} * {8'd0, geo.scale});
      prod_y = 12'({4'd0, q_rdata.row} * {8'd0, geo.scale});
      a_x0_in = $signed({geo.left_offset[11], geo.left_offset}) + $signed({1'b0, prod_x});
      a_y0_in = {1'b0, cfg.top} + {1'b0, prod_y};
      a_valid_in = a_valid_ff;
      if (q_rd) begin
         a_valid_in = 1'b1;
      end else if (a_move) begin
         a_valid_in = 1'b0;
      end
   end

   always_comb begin
      xs = $signed({a_x0_ff[12], a_x0_ff});
      ys = $signed({1'b0, a_y0_ff});
      sc = $signed({10'd0, geo.scale});
      xend = xs + sc - 14'sd1;
      yend = ys + sc - 14'sd1;
      wm1 = $signed({3'd0, cfg.width}) - 14'sd1;
      hm1 = $signed({2'd0, cfg.height}) - 14'sd1;
      xlo = xs[13] ? 14'sd0 : xs;
      xhi = (wm1 < xend) ? wm1 : xend;
      yhi = (hm1 < yend) ? hm1 : yend;
      b_empty_in = (xlo > xhi) || (ys > yhi);
      b_xlo_in = xlo[10:0];
      b_xhi_in = xhi[10:0];
      b_ylo_in = ys[11:0];
      b_yhi_in = yhi[11:0];
      b_valid_in = b_valid_ff;
      if (a_move) begin
         b_valid_in = 1'b1;
      end else if (b_take) begin
         b_valid_in = 1'b0;
      end
   end

   always_comb begin
      it_active_in = it_active_ff;
      it_x_in = it_x_ff;
      it_xlo_in = it_xlo_ff;
      it_xhi_in = it_xhi_ff;
      it_y_in = it_y_ff;
      it_yhi_in = it_yhi_ff;
      if (it_load) begin
         it_active_in = 1'b1;
         it_x_in = b_xlo_ff;
         it_xlo_in = b_xlo_ff;
         it_xhi_in = b_xhi_ff;
         it_y_in = b_ylo_ff;
         it_yhi_in = b_yhi_ff;
      end else if (it_step && it_last) begin
         it_active_in = 1'b0;
      end else if (it_step) begin
         if (it_x_ff == it_xhi_ff) begin
            it_x_in = it_xlo_ff;
            it_y_in = it_y_ff + 12'd1;
         end else begin
            it_x_in = it_x_ff + 11'd1;
         end
      end
   end

   always_comb begin
      p_valid_in = p_valid_ff;
      p_x_in = p_x_ff;
      p_y_in = p_y_ff;
      p_last_in = p_last_ff;
      if (p_ready) begin
         p_valid_in = it_active_ff;
         p_x_in = it_x_ff;
         p_y_in = it_y_ff;
         p_last_in = it_last;
      end
   end

   always_comb begin
      byte_full = 21'({9'd0, p_y_ff} * {12'd0, cfg.stride}) + {13'd0, p_x_ff[10:3]};
      out_wr = p_valid_ff && !out_full;
      out_wdata.byte_index = byte_full[19:0];
      out_wdata.bit_number = 3'd7 - p_x_ff[2:0];
      out_wdata.side = geo.side;
      out_wdata.last = p_last_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         it_active_ff <= 1'b0;
         p_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= a_valid_in;
         b_valid_ff <= b_valid_in;
         it_active_ff <= it_active_in;
         p_valid_ff <= p_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (q_rd) begin
         a_x0_ff <= a_x0_in;
         a_y0_ff <= a_y0_in;
      end
      if (a_move) begin
         b_empty_ff <= b_empty_in;
         b_xlo_ff <= b_xlo_in;
         b_xhi_ff <= b_xhi_in;
         b_ylo_ff <= b_ylo_in;
         b_yhi_ff <= b_yhi_in;
      end
      it_x_ff <= it_x_in;
      it_xlo_ff <= it_xlo_in;
      it_xhi_ff <= it_xhi_in;
      it_y_ff <= it_y_in;
      it_yhi_ff <= it_yhi_in;
      p_x_ff <= p_x_in;
      p_y_ff <= p_y_in;
      p_last_ff <= p_last_in;
   end

endmodule
